// File: src/imucal_pkg.sv
// ----------------------------------------------------------------------------
// imucal_pkg
// Shared types and constants for the IMU calibration and low-pass block.
// ----------------------------------------------------------------------------
package imucal_pkg;

   localparam int SAMPLE_W = 32;
   localparam int CSR_W    = 63;
   localparam int CSR_IDX_W = 3;
   localparam int COEF_W   = 21;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_GYRO_ROW_X  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GYRO_ROW_Y  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GYRO_ROW_Z  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ACCEL_ROW_X = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ACCEL_ROW_Y = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ACCEL_ROW_Z = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_GYRO_OFFS   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_ACCEL_OFFS  = 3'd7;

   localparam logic [CSR_W-1:0] ROW_X_RESET = 63'd262144;
   localparam logic [CSR_W-1:0] ROW_Y_RESET = 63'd549755813888;
   localparam logic [CSR_W-1:0] ROW_Z_RESET = 63'd1152921504606846976;

   // biases in Q16.16
   localparam logic signed [33:0] GYRO_BIAS_X  = -34'sd203;
   localparam logic signed [33:0] GYRO_BIAS_Y  = 34'sd12;
   localparam logic signed [33:0] GYRO_BIAS_Z  = 34'sd125;
   localparam logic signed [33:0] ACCEL_BIAS_X = 34'sd3165;
   localparam logic signed [33:0] ACCEL_BIAS_Y = 34'sd3165;
   localparam logic signed [33:0] ACCEL_BIAS_Z = -34'sd1999;

   // filter coefficients, Q2.30
   localparam logic signed [32:0] FLT_A1 = 33'sd2071735500;
   localparam logic signed [32:0] FLT_A2 = -33'sd1000494913;
   localparam logic signed [32:0] FLT_B  = 33'sd2501237;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] gx, gy, gz, ax, ay, az;
   } sample_type;

   function automatic logic signed [SAMPLE_W-1:0] sat32(input logic signed [66:0] v);
      logic signed [66:0] hi, lo;
      hi = 67'sd2147483647;
      lo = -67'sd2147483648;
      if (v > hi) return 32'sh7fffffff;
      else if (v < lo) return 32'sh80000000;
      else return v[SAMPLE_W-1:0];
   endfunction

endpackage

// File: src/imucal_front.sv
// ----------------------------------------------------------------------------
// imucal_front
// Takes raw samples, removes biases and queues them for the compute engine.
// ----------------------------------------------------------------------------
module imucal_front #(
   parameter int Depth = imucal_pkg::QUEUE_DEPTH
) (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  imucal_pkg::sample_type in_data,
   output logic out_valid,
   input  logic out_ready,
   output logic signed [33:0] out_corr [6]
);
   localparam int PW = $clog2(Depth);

   logic signed [33:0] mem_ff [Depth][6];
   logic [PW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [PW:0] cnt_ff, cnt_in;
   logic signed [33:0] corr [6];
   logic push, pop;

   always_comb begin
      corr[0] = 34'(in_data.gx) + imucal_pkg::GYRO_BIAS_X;
      corr[1] = 34'(in_data.gy) + imucal_pkg::GYRO_BIAS_Y;
      corr[2] = 34'(in_data.gz) + imucal_pkg::GYRO_BIAS_Z;
      corr[3] = 34'(in_data.ax) + imucal_pkg::ACCEL_BIAS_X;
      corr[4] = 34'(in_data.ay) + imucal_pkg::ACCEL_BIAS_Y;
      corr[5] = 34'(in_data.az) + imucal_pkg::ACCEL_BIAS_Z;
   end

   assign in_ready  = (cnt_ff != (PW+1)'(Depth));
   assign out_valid = (cnt_ff != '0);
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_comb begin
      wp_in  = push ? ((wp_ff == PW'(Depth-1)) ? '0 : wp_ff + 1'b1) : wp_ff;
      rp_in  = pop  ? ((rp_ff == PW'(Depth-1)) ? '0 : rp_ff + 1'b1) : rp_ff;
      cnt_in = cnt_ff + (PW+1)'(push) - (PW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in; rp_ff <= rp_in; cnt_ff <= cnt_in;
      end
      if (push) begin
         for (int k = 0; k < 6; k++) mem_ff[wp_ff][k] <= corr[k];
      end
   end

   always_comb begin
      for (int k = 0; k < 6; k++) out_corr[k] = mem_ff[rp_ff][k];
   end
endmodule

// File: src/imucal_back.sv
// ----------------------------------------------------------------------------
// imucal_back
// Sequencer with one shared multiplier: matrix rows, offsets and the IIR.
// ----------------------------------------------------------------------------
module imucal_back (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  logic signed [33:0] in_corr [6],
   input  logic [imucal_pkg::CSR_W-1:0] csr [8],
   output logic out_valid,
   input  logic out_ready,
   output logic signed [31:0] out_res [9]
);
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MAT  = 2'd1;
   localparam logic [1:0] ST_FLT  = 2'd2;
   localparam logic [1:0] ST_OUT  = 2'd3;

   logic [1:0] st_ff, st_in;
   logic [2:0] row_ff, row_in;   // output axis 0..5 or filter axis 0..2
   logic [1:0] col_ff, col_in;   // product index in the current sum
   logic signed [33:0] corr_ff [6];
   logic signed [66:0] acc_ff, acc_in;
   logic signed [31:0] res_ff [9];
   logic signed [31:0] y1_ff [3];
   logic signed [31:0] y2_ff [3];
   logic signed [33:0] ma;
   logic signed [32:0] mb;
   logic signed [66:0] prod, rnd;
   logic [imucal_pkg::CSR_W-1:0] rowreg, offreg;
   logic signed [20:0] offv;
   logic [2:0] start_row;
   logic signed [66:0] acc_start;
   logic signed [31:0] sv;
   logic last;

   assign in_ready  = (st_ff == ST_IDLE);
   assign out_valid = (st_ff == ST_OUT);
   always_comb for (int k = 0; k < 9; k++) out_res[k] = res_ff[k];

   always_comb begin
      rowreg = csr[row_ff];
      ma = '0; mb = '0;
      if (st_ff == ST_MAT) begin
         ma = corr_ff[(row_ff < 3'd3) ? {1'b0, col_ff} : {1'b0, col_ff} + 3'd3];
         case (col_ff)
            2'd0:    mb = 33'(signed'(rowreg[20:0]));
            2'd1:    mb = 33'(signed'(rowreg[41:21]));
            default: mb = 33'(signed'(rowreg[62:42]));
         endcase
      end else begin
         case (col_ff)
            2'd0: begin ma = 34'(y1_ff[row_ff[1:0]]); mb = imucal_pkg::FLT_A1; end
            2'd1: begin ma = 34'(y2_ff[row_ff[1:0]]); mb = imucal_pkg::FLT_A2; end
            default: begin
               ma = 34'(res_ff[4'(row_ff) + 4'd3]); mb = imucal_pkg::FLT_B;
            end
         endcase
      end
      prod = 67'(ma) * 67'(mb);
      last = (col_ff == 2'd2);
      if (st_ff == ST_MAT) rnd = (acc_ff + prod + 67'sd131072) >>> 18;
      else                 rnd = (acc_ff + prod + 67'sd536870912) >>> 30;
      sv = imucal_pkg::sat32(rnd);
   end

   // offset term preloaded whenever a matrix row starts
   always_comb begin
      start_row = (st_ff == ST_MAT) ? row_ff + 3'd1 : 3'd0;
      offreg = (start_row < 3'd3) ? csr[imucal_pkg::CSR_GYRO_OFFS]
                                  : csr[imucal_pkg::CSR_ACCEL_OFFS];
      case (start_row)
         3'd0, 3'd3: offv = offreg[20:0];
         3'd1, 3'd4: offv = offreg[41:21];
         default:    offv = offreg[62:42];
      endcase
      acc_start = 67'(offv) <<< 18;
   end

   always_comb begin
      st_in = st_ff; row_in = row_ff; col_in = col_ff; acc_in = acc_ff;
      case (st_ff)
         ST_IDLE: if (in_valid) begin
            st_in = ST_MAT; row_in = '0; col_in = '0; acc_in = acc_start;
         end
         ST_MAT: begin
            if (last) begin
               col_in = '0;
               if (row_ff == 3'd5) begin st_in = ST_FLT; row_in = '0; acc_in = '0; end
               else begin row_in = row_ff + 3'd1; acc_in = acc_start; end
            end else begin
               col_in = col_ff + 2'd1; acc_in = acc_ff + prod;
            end
         end
         ST_FLT: begin
            if (last) begin
               col_in = '0; acc_in = '0;
               if (row_ff == 3'd2) st_in = ST_OUT;
               else row_in = row_ff + 3'd1;
            end else begin
               col_in = col_ff + 2'd1; acc_in = acc_ff + prod;
            end
         end
         ST_OUT: if (out_ready) st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE; row_ff <= '0; col_ff <= '0; acc_ff <= '0;
         for (int k = 0; k < 3; k++) begin y1_ff[k] <= '0; y2_ff[k] <= '0; end
      end else begin
         st_ff <= st_in; row_ff <= row_in; col_ff <= col_in; acc_ff <= acc_in;
         if (st_ff == ST_FLT && last) begin
            y2_ff[row_ff[1:0]] <= y1_ff[row_ff[1:0]];
            y1_ff[row_ff[1:0]] <= sv;
         end
      end
      if (st_ff == ST_IDLE && in_valid)
         for (int k = 0; k < 6; k++) corr_ff[k] <= in_corr[k];
      if (st_ff == ST_MAT && last) res_ff[4'(row_ff)] <= sv;
      if (st_ff == ST_FLT && last) res_ff[4'(row_ff) + 4'd6] <= sv;
   end
endmodule

// File: src/imu_calibrate_and_lowpass_unit.sv
// ----------------------------------------------------------------------------
// imu_calibrate_and_lowpass_unit
// Six-axis IMU bias/matrix calibration with second-order accel low-pass.
// ----------------------------------------------------------------------------
// usage:
//  req_ channel carries one raw sample (six Q16.16 axes); rsp_ channel returns
//  calibrated gyro, calibrated accel and filtered accel. csr_ writes one of the
//  eight 63-bit registers (index 0..7) and is always ready.
//  the front removes biases and holds up to two samples in a small queue; the
//  back runs one shared 34x33 multiplier: 18 matrix products then 9 filter
//  products, one per cycle, so rsp_valid rises once the last filter product
//  is done; the back takes no new sample from the queue until the result has
//  been taken on rsp_, since it accepts a sample only while idle.
//  the result stays in its register until rsp_ready; while it waits the front
//  still takes new samples into the queue. reset (synchronous) restores the
//  identity matrices, zero offsets and clears the filter history.
// ----------------------------------------------------------------------------
module imu_calibrate_and_lowpass_unit #(
   parameter int QueueDepth = imucal_pkg::QUEUE_DEPTH
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic signed [31:0] req_raw_gyro_x, req_raw_gyro_y, req_raw_gyro_z,
   input  logic signed [31:0] req_raw_accel_x, req_raw_accel_y, req_raw_accel_z,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic signed [31:0] rsp_cal_gyro_x, rsp_cal_gyro_y, rsp_cal_gyro_z,
   output logic signed [31:0] rsp_cal_accel_x, rsp_cal_accel_y, rsp_cal_accel_z,
   output logic signed [31:0] rsp_smooth_accel_x, rsp_smooth_accel_y, rsp_smooth_accel_z,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [imucal_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [63:0] csr_wdata
);
   logic [imucal_pkg::CSR_W-1:0] csr_ff [8];
   imucal_pkg::sample_type smp;
   logic q_valid, q_ready;
   logic signed [33:0] q_corr [6];
   logic signed [31:0] res [9];

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff[0] <= imucal_pkg::ROW_X_RESET; csr_ff[1] <= imucal_pkg::ROW_Y_RESET;
         csr_ff[2] <= imucal_pkg::ROW_Z_RESET; csr_ff[3] <= imucal_pkg::ROW_X_RESET;
         csr_ff[4] <= imucal_pkg::ROW_Y_RESET; csr_ff[5] <= imucal_pkg::ROW_Z_RESET;
         csr_ff[6] <= '0; csr_ff[7] <= '0;
      end else if (csr_valid) begin
         csr_ff[csr_index] <= csr_wdata[imucal_pkg::CSR_W-1:0];
      end
   end

   assign smp = '{gx: req_raw_gyro_x, gy: req_raw_gyro_y, gz: req_raw_gyro_z,
                  ax: req_raw_accel_x, ay: req_raw_accel_y, az: req_raw_accel_z};

   imucal_front #(.Depth(QueueDepth)) u_front (
      .clock, .reset, .in_valid(req_valid), .in_ready(req_ready), .in_data(smp),
      .out_valid(q_valid), .out_ready(q_ready), .out_corr(q_corr));

   imucal_back u_back (
      .clock, .reset, .in_valid(q_valid), .in_ready(q_ready), .in_corr(q_corr),
      .csr(csr_ff), .out_valid(rsp_valid), .out_ready(rsp_ready), .out_res(res));

   assign rsp_cal_gyro_x = res[0]; assign rsp_cal_gyro_y = res[1];
   assign rsp_cal_gyro_z = res[2]; assign rsp_cal_accel_x = res[3];
   assign rsp_cal_accel_y = res[4]; assign rsp_cal_accel_z = res[5];
   assign rsp_smooth_accel_x = res[6]; assign rsp_smooth_accel_y = res[7];
   assign rsp_smooth_accel_z = res[8];

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_smooth_accel_x))
      else $error("result changed while stalled");
   a_csr_reset: assert property (@(posedge clock)
      $past(reset) |-> csr_ff[6] == '0 && csr_ff[7] == '0)
      else $error("offset registers not cleared");
endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu calibration and low-pass testbench
// Drives raw six-axis samples through the calibration unit, mostly under random
// idling on both channels, predicts all but one result from a behavioural
// model of bias removal, matrix, offsets and the accel filter, and checks each
// transfer field by field. Register settings change between phases while idle.
// ----------------------------------------------------------------------------
module testbench;

   localparam int N_RANDOM   = 830;
   localparam int WATCHDOG   = 20000;
   localparam int DRAIN_WAIT = 80;

   typedef struct {
      logic signed [31:0] v [9];
      bit                 fixed;
   } cal_result_type;

   typedef struct {
      logic signed [31:0] raw [6];
      bit                 has_exp;
      logic signed [31:0] exp [9];
   } stim_row_type;

   logic clock, reset;
   logic req_valid, req_ready;
   logic signed [31:0] req_raw_gyro_x, req_raw_gyro_y, req_raw_gyro_z;
   logic signed [31:0] req_raw_accel_x, req_raw_accel_y, req_raw_accel_z;
   logic rsp_valid, rsp_ready;
   logic signed [31:0] rsp_cal_gyro_x, rsp_cal_gyro_y, rsp_cal_gyro_z;
   logic signed [31:0] rsp_cal_accel_x, rsp_cal_accel_y, rsp_cal_accel_z;
   logic signed [31:0] rsp_smooth_accel_x, rsp_smooth_accel_y, rsp_smooth_accel_z;
   logic csr_valid, csr_ready;
   logic [imucal_pkg::CSR_IDX_W-1:0] csr_index;
   logic [63:0] csr_wdata;

   imu_calibrate_and_lowpass_unit uut (.*);

   // behavioural state
   logic [imucal_pkg::CSR_W-1:0] csr_shadow [8];
   longint            filt_y1 [3], filt_y2 [3];
   cal_result_type    pending_results [$];
   int                fail_count;
   int                idle_cycles;
   bit                rx_idle_enable, rx_long_hold, stim_done;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic longint field21(logic [imucal_pkg::CSR_W-1:0] r, int k);
      logic signed [20:0] f;
      f = r[21*k +: 21];
      return longint'(f);
   endfunction

   function automatic longint rnd_shift(longint v, int sh);
      return (v + (longint'(1) << (sh - 1))) >>> sh;
   endfunction

   function automatic longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // advances the filter history
   function automatic cal_result_type calibrate_sample(logic signed [31:0] raw [6]);
      cal_result_type r;
      longint gyro_bias [3], accel_bias [3], corr [6], acc, sm;
      int base;
      gyro_bias = '{-203, 12, 125};
      accel_bias = '{3165, 3165, -1999};
      for (int i = 0; i < 3; i++) begin
         corr[i] = longint'(raw[i]) + gyro_bias[i];
         corr[3+i] = longint'(raw[3+i]) + accel_bias[i];
      end
      for (int s = 0; s < 2; s++) begin
         base = 3 * s;
         for (int i = 0; i < 3; i++) begin
            acc = field21(csr_shadow[imucal_pkg::CSR_GYRO_OFFS + s], i) <<< 18;
            for (int j = 0; j < 3; j++)
               acc += corr[base+j] * field21(csr_shadow[base+i], j);
            r.v[base+i] = 32'(clip32(rnd_shift(acc, 18)));
         end
      end
      for (int i = 0; i < 3; i++) begin
         acc = filt_y1[i] * 2071735500 + filt_y2[i] * (-1000494913)
             + longint'(r.v[3+i]) * 2501237;
         sm = clip32(rnd_shift(acc, 30));
         filt_y2[i] = filt_y1[i];
         filt_y1[i] = sm;
         r.v[6+i] = 32'(sm);
      end
      r.fixed = 1'b0;
      return r;
   endfunction

   task automatic report_mismatch(string what, int field, longint got, longint want);
      $display("mismatch %s field %0d: got %0d expected %0d", what, field, got, want);
      fail_count++;
   endtask

   // ---- configuration ----
   task automatic write_csr(logic [imucal_pkg::CSR_IDX_W-1:0] idx, logic [63:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_shadow[idx] = data[imucal_pkg::CSR_W-1:0];
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [62:0] pack3(int a, int b, int c);
      logic [20:0] fa, fb, fc;
      fa = 21'(a); fb = 21'(b); fc = 21'(c);
      return {fc, fb, fa};
   endfunction

   task automatic wait_drained();
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   // ---- input channel ----
   // valid stays up between back-to-back transfers; callers drop it after a run
   task automatic send_sample(logic signed [31:0] raw [6], bit idle, cal_result_type exp);
      if (idle && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_valid <= 1'b1;
      {req_raw_gyro_x, req_raw_gyro_y, req_raw_gyro_z} <= {raw[0], raw[1], raw[2]};
      {req_raw_accel_x, req_raw_accel_y, req_raw_accel_z} <= {raw[3], raw[4], raw[5]};
      do @(posedge clock); while (!req_ready);
      if (exp.fixed) begin
         void'(calibrate_sample(raw));
         pending_results.push_back(exp);
      end else begin
         pending_results.push_back(calibrate_sample(raw));
      end
      @(negedge clock);
   endtask

   function automatic logic signed [31:0] rand_axis();
      case ($urandom_range(0, 5))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2: return $signed(32'($urandom_range(0, 20)) - 32'sd10);
         3: return $signed($urandom_range(0, 32'h0003ffff)) - 32'sh0001ffff;
         default: return $signed($urandom());
      endcase
   endfunction

   task automatic random_phase(int count, bit idle);
      logic signed [31:0] raw [6];
      cal_result_type none;
      none.fixed = 1'b0;
      for (int n = 0; n < count; n++) begin
         foreach (raw[i]) raw[i] = rand_axis();
         send_sample(raw, idle, none);
      end
      req_valid <= 1'b0;
   endtask

   function automatic int rand_coef();
      case ($urandom_range(0, 4))
         0: return 1048575;
         1: return -1048576;
         2: return 262144;
         default: return int'($urandom_range(0, 600000)) - 300000;
      endcase
   endfunction

   task automatic random_config();
      for (int r = 0; r < 6; r++)
         write_csr(r[2:0], {1'($urandom), pack3(rand_coef(), rand_coef(), rand_coef())});
      write_csr(imucal_pkg::CSR_GYRO_OFFS, {$urandom(), $urandom()});
      write_csr(imucal_pkg::CSR_ACCEL_OFFS, {$urandom(), $urandom()});
   endtask

   // ---- result channel ----
   initial begin
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (rx_long_hold) begin
            rsp_ready <= 1'b0;
            repeat (200) @(negedge clock);
            rx_long_hold = 1'b0;
         end
         if (rx_idle_enable && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      cal_result_type want;
      logic signed [31:0] got [9];
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_cal_gyro_x, rsp_cal_gyro_y, rsp_cal_gyro_z,
                 rsp_cal_accel_x, rsp_cal_accel_y, rsp_cal_accel_z,
                 rsp_smooth_accel_x, rsp_smooth_accel_y, rsp_smooth_accel_z};
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result transfer", 0, 0, 0);
         end else begin
            want = pending_results.pop_front();
            for (int i = 0; i < 9; i++)
               if (got[i] !== want.v[i]) report_mismatch("result", i, got[i], want.v[i]);
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready) || stim_done)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
         $display("Verification failed");
         $finish;
      end
   end

   // ---- main sequence ----
   initial begin
      stim_row_type dir_table [$];
      stim_row_type row;
      cal_result_type exp;

      reset = 1'b1;
      req_valid = 1'b0; csr_valid = 1'b0; csr_index = '0; csr_wdata = '0;
      {req_raw_gyro_x, req_raw_gyro_y, req_raw_gyro_z} = '0;
      {req_raw_accel_x, req_raw_accel_y, req_raw_accel_z} = '0;
      fail_count = 0; idle_cycles = 0;
      rx_idle_enable = 1'b1; rx_long_hold = 1'b0; stim_done = 1'b0;
      csr_shadow = '{imucal_pkg::ROW_X_RESET, imucal_pkg::ROW_Y_RESET,
                     imucal_pkg::ROW_Z_RESET, imucal_pkg::ROW_X_RESET,
                     imucal_pkg::ROW_Y_RESET, imucal_pkg::ROW_Z_RESET, '0, '0};
      foreach (filt_y1[i]) begin filt_y1[i] = 0; filt_y2[i] = 0; end
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // after reset: identity and zero history; zero input gives the biases
      row.raw = '{0, 0, 0, 0, 0, 0};
      row.has_exp = 1'b1;
      row.exp = '{-203, 12, 125, 3165, 3165, -1999, 7, 7, -5};
      dir_table.push_back(row);
      row.has_exp = 1'b0;
      row.raw = '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                  32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff};
      dir_table.push_back(row);
      row.raw = '{32'sh80000000, 32'sh80000000, 32'sh80000000,
                  32'sh80000000, 32'sh80000000, 32'sh80000000};
      dir_table.push_back(row);
      row.raw = '{32'sh7fffffff, 32'sh80000000, -1, 1, 32'sh80000000, 32'sh7fffffff};
      dir_table.push_back(row);
      for (int k = 0; k < 8; k++) begin
         row.raw = '{65536, -65536, 32768, 643000, -643000, 0};
         dir_table.push_back(row);
      end

      foreach (dir_table[n]) begin
         exp.fixed = dir_table[n].has_exp;
         exp.v = dir_table[n].exp;
         send_sample(dir_table[n].raw, 1'b0, exp);
      end
      req_valid <= 1'b0;
      wait_drained();

      // extreme matrices and offsets: every matrix coefficient at its limits
      for (int r = 0; r < 6; r++)
         write_csr(r[2:0], {1'b1, pack3(1048575, -1048576, 1048575)});
      write_csr(imucal_pkg::CSR_GYRO_OFFS, {1'b1, pack3(1048575, -1048576, 0)});
      write_csr(imucal_pkg::CSR_ACCEL_OFFS, {1'b0, pack3(-1048576, 1048575, 1)});
      foreach (dir_table[n]) begin
         if (n >= 4) break;
         exp.fixed = 1'b0;
         send_sample(dir_table[n].raw, 1'b0, exp);
      end
      req_valid <= 1'b0;
      wait_drained();

      write_csr(imucal_pkg::CSR_GYRO_OFFS, '1);
      write_csr(imucal_pkg::CSR_ACCEL_OFFS, '1);
      for (int r = 0; r < 6; r++) write_csr(r[2:0], '0);
      random_phase(6, 1'b1);
      wait_drained();

      // random phases, each under a new register setting
      for (int ph = 0; ph < 5; ph++) begin
         random_config();
         if (ph == 1) rx_long_hold = 1'b1;
         random_phase(130, 1'b1);
         wait_drained();
      end

      // back to identity with random offsets, then no idling at the end
      write_csr(imucal_pkg::CSR_GYRO_ROW_X, imucal_pkg::ROW_X_RESET);
      write_csr(imucal_pkg::CSR_GYRO_ROW_Y, imucal_pkg::ROW_Y_RESET);
      write_csr(imucal_pkg::CSR_GYRO_ROW_Z, imucal_pkg::ROW_Z_RESET);
      write_csr(imucal_pkg::CSR_ACCEL_ROW_X, imucal_pkg::ROW_X_RESET);
      write_csr(imucal_pkg::CSR_ACCEL_ROW_Y, imucal_pkg::ROW_Y_RESET);
      write_csr(imucal_pkg::CSR_ACCEL_ROW_Z, imucal_pkg::ROW_Z_RESET);
      write_csr(imucal_pkg::CSR_GYRO_OFFS, {$urandom(), $urandom()});
      write_csr(imucal_pkg::CSR_ACCEL_OFFS, {$urandom(), $urandom()});
      random_phase(100, 1'b1);
      rx_idle_enable = 1'b0;
      random_phase(80, 1'b0);

      stim_done = 1'b1;
      fork
         begin
            wait_drained();
            if (fail_count == 0)
               $display("Verification passed");
            else
               $display("Verification failed");
         end
         begin
            repeat (WATCHDOG) @(posedge clock);
            $display("Verification failed");
         end
      join_any
      $finish;
   end

endmodule
